// ===== hdl/sha_pkg.sv =====
// Package for the SHA-256 block hasher: round constants, initial hash values
// and the sigma/choose/majority helpers.
// No dependencies.
package sha_pkg;

	localparam int WORD_W   = 32;
	localparam int NUM_H    = 8;
	localparam int WIN_LEN  = 16;
	localparam int ROUNDS   = 64;
	localparam int ROUND_W  = $clog2(ROUNDS);
	localparam int WCNT_W   = $clog2(WIN_LEN);
	localparam int HIDX_W   = $clog2(NUM_H);

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t INIT_HASH [NUM_H] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t majority(input word_t a, input word_t b, input word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ===== hdl/sha256_block_hasher.sv =====
// SHA-256 hasher over pre-padded 32-bit big-endian message words.
// Depends on sha_pkg. One shared round unit iterates 64 times per block.
//
//   channel   signals                                      direction
//   -------   ------------------------------------------   ---------
//   input     in_valid/in_ready, msg_word, msg_start,      in
//             msg_end
//   output    out_valid/out_ready, digest_word,            out
//             digest_index, digest_last
//
// Words are taken one per cycle while idle. The sixteenth word of a block
// starts the rounds in S_ROUND and then the chaining add in S_ADD; the block
// rate is bounded by the single round unit.
// An end word then adds 8 digest items, one per cycle when out_ready is high;
// in_ready stays low until the last one is taken. A stalled out_ready holds
// the current digest item. Reset loads the initial hash and clears all counts.
module sha256_block_hasher
	import sha_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       msg_word,
	input  logic              msg_start,
	input  logic              msg_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        digest_index,
	output logic              digest_last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROUND,
		S_ADD,
		S_DIGEST
	} state_t;

	state_t              state_q;
	word_t               chain_q [NUM_H];
	word_t               work_q  [NUM_H];
	word_t               win_q   [WIN_LEN];
	logic [WCNT_W-1:0]   word_cnt_q;
	logic [ROUND_W-1:0]  round_q;
	logic [HIDX_W-1:0]   dig_idx_q;
	logic                end_pend_q;

	logic                in_acc;
	logic                out_acc;
	logic [WCNT_W-1:0]   word_cnt_nxt;
	word_t               w_cur;
	word_t               w_new;
	word_t               t1;
	word_t               t2;

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = (state_q == S_DIGEST);
	assign in_acc       = in_valid && in_ready;
	assign out_acc      = out_valid && out_ready;
	assign digest_index = dig_idx_q;
	assign digest_last  = (dig_idx_q == HIDX_W'(NUM_H - 1));
	assign digest_word  = chain_q[dig_idx_q];

	assign word_cnt_nxt = msg_start ? WCNT_W'(1) : word_cnt_q + WCNT_W'(1);

	// Window tap 0 is W[t]; the pushed word is W[t+16].
	assign w_cur = win_q[0];
	assign w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

	assign t1 = work_q[7] + big_sigma1(work_q[4]) + choose(work_q[4], work_q[5], work_q[6])
		+ ROUND_K[round_q] + w_cur;
	assign t2 = big_sigma0(work_q[0]) + majority(work_q[0], work_q[1], work_q[2]);

	// Message schedule window: shifts on every accepted word and every round.
	always_ff @(posedge clk) begin
		if (in_acc || state_q == S_ROUND) begin
			for (int i = 0; i < WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_LEN-1] <= (state_q == S_ROUND) ? w_new : msg_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			chain_q    <= INIT_HASH;
			for (int i = 0; i < NUM_H; i++) begin
				work_q[i] <= '0;
			end
			word_cnt_q <= '0;
			round_q    <= '0;
			dig_idx_q  <= '0;
			end_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (msg_start) begin
							chain_q <= INIT_HASH;
						end
						if (word_cnt_nxt == '0) begin
							// block complete; start cannot be set here
							work_q     <= chain_q;
							round_q    <= '0;
							end_pend_q <= msg_end;
							word_cnt_q <= '0;
							state_q    <= S_ROUND;
						end else if (msg_end) begin
							// partial block dropped, current chain is the digest
							word_cnt_q <= '0;
							dig_idx_q  <= '0;
							state_q    <= S_DIGEST;
						end else begin
							word_cnt_q <= word_cnt_nxt;
						end
					end
				end
				S_ROUND: begin
					for (int i = 1; i < NUM_H; i++) begin
						if (i != 4) begin
							work_q[i] <= work_q[i-1];
						end
					end
					work_q[4] <= work_q[3] + t1;
					work_q[0] <= t1 + t2;
					round_q   <= round_q + ROUND_W'(1);
					if (round_q == ROUND_W'(ROUNDS - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					for (int i = 0; i < NUM_H; i++) begin
						chain_q[i] <= chain_q[i] + work_q[i];
					end
					dig_idx_q <= '0;
					state_q   <= end_pend_q ? S_DIGEST : S_IDLE;
				end
				S_DIGEST: begin
					if (out_acc) begin
						dig_idx_q <= dig_idx_q + HIDX_W'(1);
						if (digest_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/sha_checker.sv =====
// Port-level checks for sha256_block_hasher, bound into that module.
// Depends on sha_pkg.
module sha_checker
	import sha_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        msg_start,
	input logic        msg_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  digest_index,
	input logic        digest_last
);

	// A message of one start+end word yields the initial hash as its digest; the first digest item is checked.
	a_short_msg: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && msg_start && msg_end |=>
			out_valid && digest_index == 3'd0 && digest_word == INIT_HASH[0])
		else $error("start+end item did not yield initial hash");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while digest pending");

	a_digest_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !digest_last |=>
			out_valid && digest_index == $past(digest_index) + 3'd1)
		else $error("digest items not contiguous");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word)
			&& $stable(digest_index))
		else $error("stalled digest item changed");

endmodule

bind sha256_block_hasher sha_checker u_sha_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.msg_start    (msg_start),
	.msg_end      (msg_end),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.digest_word  (digest_word),
	.digest_index (digest_index),
	.digest_last  (digest_last)
);
